FILE: hw/rtl/rcpc_pkg.sv
// ----------------------------------------------------------------------------
// rcpc_pkg
// Shared types and constants of the ray against convex polygon clip test:
// sequencer states, multiplier operand selects, accumulator operations and
// the control and status groups between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package rcpc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DOT,
    ST_CMP,
    ST_NEXT,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    A_PX,
    A_PY,
    A_DX,
    A_DY,
    A_N1H,
    A_N1L,
    A_N2H,
    A_N2L
  } a_sel_e;

  typedef enum logic [2:0] {
    B_NX,
    B_NY,
    B_D1H,
    B_D1L,
    B_D2H,
    B_D2L
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    SH_0,
    SH_1,
    SH_2
  } shift_e;

  typedef struct packed {
    logic    accept;
    logic    first;
    logic    setup;
    logic    edge_close;
    logic    cap_num;
    logic    cap_den;
    logic    upd_entry;
    logic    upd_exit;
    logic    bound_exit;
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    acc_op_e acc_op;
    shift_e  shift;
  } ctl_t;

  typedef struct packed {
    logic acc_neg;
    logic acc_zero;
    logic num_neg;
  } stat_t;

  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_ONE = 4'd1;
  localparam logic [CNT_W-1:0] DOT_LAST = 4'd6;
  localparam logic [CNT_W-1:0] CMP_LAST = 4'd9;

  localparam int unsigned OUT_W = 8;

endpackage

FILE: hw/rtl/rcpc_datapath.sv
// ----------------------------------------------------------------------------
// rcpc_datapath
// Latched ray and polygon vertices, edge vector setup, the shared signed
// multiplier with its product register, the shifting accumulator, and the
// edge numerator, denominator and the entry and exit bound fractions.
// ----------------------------------------------------------------------------
module rcpc_datapath #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rcpc_pkg::ctl_t               ctl_i,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic signed [COORD_BITS-1:0] origin_x_i,
  input  logic signed [COORD_BITS-1:0] origin_y_i,
  input  logic signed [COORD_BITS-1:0] dir_x_i,
  input  logic signed [COORD_BITS-1:0] dir_y_i,
  output rcpc_pkg::stat_t              stat_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned H  = C + 1;
  localparam int unsigned W  = 2 * H + 1;
  localparam int unsigned M  = H + 2;
  localparam int unsigned PW = 2 * M;
  localparam int unsigned AW = 4 * H + 3;

  logic signed [C-1:0] ox_q, oy_q, dx_q, dy_q;
  logic signed [C-1:0] sx_q, sy_q, prx_q, pry_q, vx_q, vy_q;
  logic signed [H-1:0] px_q, py_q, nx_q, ny_q;
  logic signed [H-1:0] ax, ay, bx, by;
  logic signed [W-1:0] num_q, den_q;
  logic signed [W-1:0] en_n_q, en_d_q, ex_n_q, ex_d_q;
  logic signed [W-1:0] n2, d2, acc_low;
  logic signed [M-1:0] op_a, op_b;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] prod_ext, shifted, acc_q, acc_d;
  rcpc_pkg::acc_op_e   pop_q;
  rcpc_pkg::shift_e    psh_q;

  always_comb begin
    if (ctl_i.edge_close) begin
      ax = {vx_q[C-1], vx_q};
      ay = {vy_q[C-1], vy_q};
      bx = {sx_q[C-1], sx_q};
      by = {sy_q[C-1], sy_q};
    end else begin
      ax = {prx_q[C-1], prx_q};
      ay = {pry_q[C-1], pry_q};
      bx = {vx_q[C-1], vx_q};
      by = {vy_q[C-1], vy_q};
    end
  end

  assign n2 = ctl_i.bound_exit ? ex_n_q : en_n_q;
  assign d2 = ctl_i.bound_exit ? ex_d_q : en_d_q;

  always_comb begin
    case (ctl_i.a_sel)
      rcpc_pkg::A_PX:  op_a = {{(M-H){px_q[H-1]}}, px_q};
      rcpc_pkg::A_PY:  op_a = {{(M-H){py_q[H-1]}}, py_q};
      rcpc_pkg::A_DX:  op_a = {{(M-C){dx_q[C-1]}}, dx_q};
      rcpc_pkg::A_DY:  op_a = {{(M-C){dy_q[C-1]}}, dy_q};
      rcpc_pkg::A_N1H: op_a = {{(M-(W-H)){num_q[W-1]}}, num_q[W-1:H]};
      rcpc_pkg::A_N1L: op_a = {{(M-H){1'b0}}, num_q[H-1:0]};
      rcpc_pkg::A_N2H: op_a = {{(M-(W-H)){n2[W-1]}}, n2[W-1:H]};
      rcpc_pkg::A_N2L: op_a = {{(M-H){1'b0}}, n2[H-1:0]};
      default:         op_a = '0;
    endcase
  end

  always_comb begin
    case (ctl_i.b_sel)
      rcpc_pkg::B_NX:  op_b = {{(M-H){nx_q[H-1]}}, nx_q};
      rcpc_pkg::B_NY:  op_b = {{(M-H){ny_q[H-1]}}, ny_q};
      rcpc_pkg::B_D1H: op_b = {{(M-(W-H)){den_q[W-1]}}, den_q[W-1:H]};
      rcpc_pkg::B_D1L: op_b = {{(M-H){1'b0}}, den_q[H-1:0]};
      rcpc_pkg::B_D2H: op_b = {{(M-(W-H)){d2[W-1]}}, d2[W-1:H]};
      rcpc_pkg::B_D2L: op_b = {{(M-H){1'b0}}, d2[H-1:0]};
      default:         op_b = '0;
    endcase
  end

  assign prod_ext = {{(AW-PW){prod_q[PW-1]}}, prod_q};

  always_comb begin
    case (psh_q)
      rcpc_pkg::SH_0: shifted = prod_ext;
      rcpc_pkg::SH_1: shifted = prod_ext << H;
      rcpc_pkg::SH_2: shifted = prod_ext << (2 * H);
      default:        shifted = prod_ext;
    endcase
  end

  always_comb begin
    case (pop_q)
      rcpc_pkg::ACC_LOAD: acc_d = shifted;
      rcpc_pkg::ACC_ADD:  acc_d = acc_q + shifted;
      rcpc_pkg::ACC_SUB:  acc_d = acc_q - shifted;
      default:            acc_d = acc_q;
    endcase
  end

  assign acc_low = acc_q[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q <= rcpc_pkg::ACC_NONE;
      psh_q <= rcpc_pkg::SH_0;
    end else begin
      pop_q <= ctl_i.acc_op;
      psh_q <= ctl_i.shift;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    acc_q  <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q   <= '0;
      oy_q   <= '0;
      dx_q   <= '0;
      dy_q   <= '0;
      sx_q   <= '0;
      sy_q   <= '0;
      prx_q  <= '0;
      pry_q  <= '0;
      vx_q   <= '0;
      vy_q   <= '0;
      px_q   <= '0;
      py_q   <= '0;
      nx_q   <= '0;
      ny_q   <= '0;
      num_q  <= '0;
      den_q  <= '0;
      en_n_q <= '0;
      en_d_q <= {{(W-1){1'b0}}, 1'b1};
      ex_n_q <= '0;
      ex_d_q <= {{(W-1){1'b0}}, 1'b1};
    end else begin
      if (ctl_i.accept) begin
        vx_q <= vertex_x_i;
        vy_q <= vertex_y_i;
        if (ctl_i.first) begin
          ox_q   <= origin_x_i;
          oy_q   <= origin_y_i;
          dx_q   <= dir_x_i;
          dy_q   <= dir_y_i;
          sx_q   <= vertex_x_i;
          sy_q   <= vertex_y_i;
          prx_q  <= vertex_x_i;
          pry_q  <= vertex_y_i;
          en_n_q <= '0;
          en_d_q <= {{(W-1){1'b0}}, 1'b1};
          ex_n_q <= '0;
          ex_d_q <= {{(W-1){1'b0}}, 1'b1};
        end
      end
      if (ctl_i.setup) begin
        nx_q <= by - ay;
        ny_q <= ax - bx;
        px_q <= ax - {ox_q[C-1], ox_q};
        py_q <= ay - {oy_q[C-1], oy_q};
        if (!ctl_i.edge_close) begin
          prx_q <= vx_q;
          pry_q <= vy_q;
        end
      end
      if (ctl_i.cap_num) begin
        num_q <= acc_low;
      end
      if (ctl_i.cap_den) begin
        den_q <= acc_q[AW-1] ? -acc_low : acc_low;
        num_q <= acc_q[AW-1] ? -num_q : num_q;
      end
      if (ctl_i.upd_entry) begin
        en_n_q <= num_q;
        en_d_q <= den_q;
      end
      if (ctl_i.upd_exit) begin
        ex_n_q <= num_q;
        ex_d_q <= den_q;
      end
    end
  end

  assign stat_o.acc_neg  = acc_q[AW-1];
  assign stat_o.acc_zero = (acc_q == '0);
  assign stat_o.num_neg  = num_q[W-1];

endmodule

FILE: hw/rtl/rcpc_seq.sv
// ----------------------------------------------------------------------------
// rcpc_seq
// Sequencer of the clip test: steps the shared multiplier through the edge
// dot products and the cross-multiplied bound compares, keeps the rejection
// and unbounded-exit flags, and holds the result register.
// ----------------------------------------------------------------------------
module rcpc_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_first_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic            hit_o,
  input  rcpc_pkg::stat_t stat_i,
  output rcpc_pkg::ctl_t  ctl_o
);

  rcpc_pkg::state_e state_q, state_d;
  logic [rcpc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic last_q, last_d;
  logic edge_close_q, edge_close_d;
  logic bound_exit_q, bound_exit_d;
  logic enter_q, enter_d;
  logic rejected_q, rejected_d;
  logic exit_unb_q, exit_unb_d;
  logic out_valid_q, out_valid_d;
  logic hit_q, hit_d;
  logic cmp_gt, cmp_lt;

  assign cmp_gt = !stat_i.acc_neg && !stat_i.acc_zero;
  assign cmp_lt = stat_i.acc_neg;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    edge_close_d = edge_close_q;
    bound_exit_d = bound_exit_q;
    enter_d      = enter_q;
    rejected_d   = rejected_q;
    exit_unb_d   = exit_unb_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    hit_d        = hit_q;
    case (state_q)
      rcpc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          last_d = in_last_i;
          if (in_first_i) begin
            rejected_d = 1'b0;
            exit_unb_d = 1'b1;
            if (in_last_i) begin
              edge_close_d = 1'b1;
              state_d      = rcpc_pkg::ST_SETUP;
            end
          end else begin
            edge_close_d = 1'b0;
            state_d      = rcpc_pkg::ST_SETUP;
          end
        end
      end
      rcpc_pkg::ST_SETUP: begin
        cnt_d   = '0;
        state_d = rejected_q ? rcpc_pkg::ST_NEXT : rcpc_pkg::ST_DOT;
      end
      rcpc_pkg::ST_DOT: begin
        if (cnt_q == rcpc_pkg::DOT_LAST) begin
          cnt_d = '0;
          if (stat_i.acc_zero) begin
            if (stat_i.num_neg) begin
              rejected_d = 1'b1;
            end
            state_d = rcpc_pkg::ST_NEXT;
          end else begin
            enter_d      = stat_i.acc_neg;
            bound_exit_d = stat_i.acc_neg && !exit_unb_q;
            state_d      = rcpc_pkg::ST_CMP;
          end
        end else begin
          cnt_d = cnt_q + rcpc_pkg::CNT_ONE;
        end
      end
      rcpc_pkg::ST_CMP: begin
        if (cnt_q == rcpc_pkg::CMP_LAST) begin
          cnt_d   = '0;
          state_d = rcpc_pkg::ST_NEXT;
          if (enter_q) begin
            if (bound_exit_q) begin
              if (cmp_gt) begin
                rejected_d = 1'b1;
              end else begin
                bound_exit_d = 1'b0;
                state_d      = rcpc_pkg::ST_CMP;
              end
            end
          end else if (!bound_exit_q) begin
            if (cmp_lt) begin
              rejected_d = 1'b1;
            end else if (exit_unb_q) begin
              exit_unb_d = 1'b0;
            end else begin
              bound_exit_d = 1'b1;
              state_d      = rcpc_pkg::ST_CMP;
            end
          end
        end else begin
          cnt_d = cnt_q + rcpc_pkg::CNT_ONE;
        end
      end
      rcpc_pkg::ST_NEXT: begin
        if (last_q && !edge_close_q) begin
          edge_close_d = 1'b1;
          state_d      = rcpc_pkg::ST_SETUP;
        end else if (last_q) begin
          state_d = rcpc_pkg::ST_OUT;
        end else begin
          state_d = rcpc_pkg::ST_IDLE;
        end
      end
      rcpc_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          hit_d       = !rejected_q;
          state_d     = rcpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rcpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl_o            = '0;
    ctl_o.accept     = (state_q == rcpc_pkg::ST_IDLE) && in_valid_i;
    ctl_o.first      = in_first_i;
    ctl_o.setup      = (state_q == rcpc_pkg::ST_SETUP);
    ctl_o.edge_close = edge_close_q;
    ctl_o.bound_exit = bound_exit_q;
    ctl_o.acc_op     = rcpc_pkg::ACC_NONE;
    ctl_o.shift      = rcpc_pkg::SH_0;
    ctl_o.a_sel      = rcpc_pkg::A_PX;
    ctl_o.b_sel      = rcpc_pkg::B_NX;
    in_ready_o       = (state_q == rcpc_pkg::ST_IDLE);
    case (state_q)
      rcpc_pkg::ST_DOT: begin
        case (cnt_q)
          4'd0: begin
            ctl_o.acc_op = rcpc_pkg::ACC_LOAD;
          end
          4'd1: begin
            ctl_o.a_sel  = rcpc_pkg::A_PY;
            ctl_o.b_sel  = rcpc_pkg::B_NY;
            ctl_o.acc_op = rcpc_pkg::ACC_ADD;
          end
          4'd3: begin
            ctl_o.cap_num = 1'b1;
            ctl_o.a_sel   = rcpc_pkg::A_DX;
            ctl_o.acc_op  = rcpc_pkg::ACC_LOAD;
          end
          4'd4: begin
            ctl_o.a_sel  = rcpc_pkg::A_DY;
            ctl_o.b_sel  = rcpc_pkg::B_NY;
            ctl_o.acc_op = rcpc_pkg::ACC_ADD;
          end
          rcpc_pkg::DOT_LAST: begin
            ctl_o.cap_den = !stat_i.acc_zero;
          end
          default: begin
            ctl_o.acc_op = rcpc_pkg::ACC_NONE;
          end
        endcase
      end
      rcpc_pkg::ST_CMP: begin
        case (cnt_q)
          4'd0: begin
            ctl_o.a_sel  = rcpc_pkg::A_N1H;
            ctl_o.b_sel  = rcpc_pkg::B_D2H;
            ctl_o.acc_op = rcpc_pkg::ACC_LOAD;
            ctl_o.shift  = rcpc_pkg::SH_2;
          end
          4'd1: begin
            ctl_o.a_sel  = rcpc_pkg::A_N1H;
            ctl_o.b_sel  = rcpc_pkg::B_D2L;
            ctl_o.acc_op = rcpc_pkg::ACC_ADD;
            ctl_o.shift  = rcpc_pkg::SH_1;
          end
          4'd2: begin
            ctl_o.a_sel  = rcpc_pkg::A_N1L;
            ctl_o.b_sel  = rcpc_pkg::B_D2H;
            ctl_o.acc_op = rcpc_pkg::ACC_ADD;
            ctl_o.shift  = rcpc_pkg::SH_1;
          end
          4'd3: begin
            ctl_o.a_sel  = rcpc_pkg::A_N1L;
            ctl_o.b_sel  = rcpc_pkg::B_D2L;
            ctl_o.acc_op = rcpc_pkg::ACC_ADD;
          end
          4'd4: begin
            ctl_o.a_sel  = rcpc_pkg::A_N2H;
            ctl_o.b_sel  = rcpc_pkg::B_D1H;
            ctl_o.acc_op = rcpc_pkg::ACC_SUB;
            ctl_o.shift  = rcpc_pkg::SH_2;
          end
          4'd5: begin
            ctl_o.a_sel  = rcpc_pkg::A_N2H;
            ctl_o.b_sel  = rcpc_pkg::B_D1L;
            ctl_o.acc_op = rcpc_pkg::ACC_SUB;
            ctl_o.shift  = rcpc_pkg::SH_1;
          end
          4'd6: begin
            ctl_o.a_sel  = rcpc_pkg::A_N2L;
            ctl_o.b_sel  = rcpc_pkg::B_D1H;
            ctl_o.acc_op = rcpc_pkg::ACC_SUB;
            ctl_o.shift  = rcpc_pkg::SH_1;
          end
          4'd7: begin
            ctl_o.a_sel  = rcpc_pkg::A_N2L;
            ctl_o.b_sel  = rcpc_pkg::B_D1L;
            ctl_o.acc_op = rcpc_pkg::ACC_SUB;
          end
          rcpc_pkg::CMP_LAST: begin
            ctl_o.upd_entry = enter_q && !bound_exit_q && cmp_gt;
            ctl_o.upd_exit  = !enter_q && ((!bound_exit_q && !cmp_lt && exit_unb_q) ||
                                           (bound_exit_q && cmp_lt));
          end
          default: begin
            ctl_o.acc_op = rcpc_pkg::ACC_NONE;
          end
        endcase
      end
      default: begin
        ctl_o.acc_op = rcpc_pkg::ACC_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rcpc_pkg::ST_IDLE;
      cnt_q        <= '0;
      last_q       <= 1'b0;
      edge_close_q <= 1'b0;
      bound_exit_q <= 1'b0;
      enter_q      <= 1'b0;
      rejected_q   <= 1'b0;
      exit_unb_q   <= 1'b1;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      last_q       <= last_d;
      edge_close_q <= edge_close_d;
      bound_exit_q <= bound_exit_d;
      enter_q      <= enter_d;
      rejected_q   <= rejected_d;
      exit_unb_q   <= exit_unb_d;
      out_valid_q  <= out_valid_d;
      hit_q        <= hit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

endmodule

FILE: hw/rtl/ray_convex_polygon_clip_test.sv
// ----------------------------------------------------------------------------
// ray_convex_polygon_clip_test
// Tests a ray against a convex polygon whose vertices arrive one per request,
// tightening exact entry and exit fractions edge by edge with one shared
// multiplier, and returns hit or miss after the last vertex.
//
// Channel   Dir  Handshake                     Content
// s_axis    in   s_axis_tvalid/s_axis_tready   vertex, ray, first and last flag
// m_axis    out  m_axis_tvalid/m_axis_tready   hit, one per last vertex
//
// A request that only opens a polygon just latches its vertex and ray;
// otherwise each edge runs a setup step, the dot products and up to two
// fraction compares on the shared multiplier, then a next step.
// The input is ready only while the sequencer is idle. A waiting result sits
// in its output register and does not stop the next request from entering;
// a later result waits until that register is free. Reset is asynchronous.
// ----------------------------------------------------------------------------
module ray_convex_polygon_clip_test #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // vertex_x, vertex_y, origin_x, origin_y, dir_x, dir_y, zero fill
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
  // first_vertex
  input  logic                                     s_axis_tuser,
  input  logic                                     s_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // hit, zero fill
  output logic [rcpc_pkg::OUT_W-1:0]               m_axis_tdata
);

  localparam int unsigned C = COORD_BITS;

  rcpc_pkg::ctl_t  ctl;
  rcpc_pkg::stat_t stat;
  logic            hit;

  rcpc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_first_i  (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .hit_o       (hit),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  rcpc_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .vertex_x_i (s_axis_tdata[C-1:0]),
    .vertex_y_i (s_axis_tdata[2*C-1:C]),
    .origin_x_i (s_axis_tdata[3*C-1:2*C]),
    .origin_y_i (s_axis_tdata[4*C-1:3*C]),
    .dir_x_i    (s_axis_tdata[5*C-1:4*C]),
    .dir_y_i    (s_axis_tdata[6*C-1:5*C]),
    .stat_o     (stat)
  );

  assign m_axis_tdata = {{(rcpc_pkg::OUT_W-1){1'b0}}, hit};

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ray against convex polygon clip test. A short
// table of hand-picked polygons and rays runs first, followed by random
// convex polygons of varied size, orientation and ray placement, mixed with
// stray vertices carrying random flags. Every accepted vertex is fed to a
// bit-exact predictor of the clip test, and each hit or miss that leaves the
// block is compared with the oldest expected one. Both stream sides stall
// in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CW = 16;
  localparam int unsigned DATA_W = ((6*CW+7)/8)*8;
  localparam int unsigned ITEM_TARGET = 750;
  localparam int unsigned CALM_FROM = 660;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam real TWO_PI = 6.283185307179586;

  typedef enum {
    VERDICT_PREDICT,
    VERDICT_HIT,
    VERDICT_MISS
  } verdict_e;

  typedef struct {
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [CW-1:0] org_x;
    logic signed [CW-1:0] org_y;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic                 first;
    logic                 last;
  } vertex_t;

  typedef struct {
    vertex_t  v;
    verdict_e want;
  } stim_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  // vertex_x, vertex_y, origin_x, origin_y, dir_x, dir_y, zero fill
  logic [DATA_W-1:0]           s_axis_tdata;
  // first_vertex
  logic                        s_axis_tuser;
  logic                        s_axis_tlast;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  // hit, zero fill
  logic [rcpc_pkg::OUT_W-1:0]  m_axis_tdata;

  ray_convex_polygon_clip_test i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predictor state of the clip test.
  logic signed [CW-1:0] ray_ox = '0;
  logic signed [CW-1:0] ray_oy = '0;
  logic signed [CW-1:0] ray_dx = '0;
  logic signed [CW-1:0] ray_dy = '0;
  logic signed [CW-1:0] open_x = '0;
  logic signed [CW-1:0] open_y = '0;
  logic signed [CW-1:0] prev_x = '0;
  logic signed [CW-1:0] prev_y = '0;
  logic signed [35:0]   entry_num = 36'sd0;
  logic signed [35:0]   entry_den = 36'sd1;
  logic signed [35:0]   exit_num = 36'sd0;
  logic signed [35:0]   exit_den = 36'sd1;
  bit                   exit_open = 1'b1;
  bit                   ray_dead = 1'b0;

  bit          hit_expect_q[$];
  stim_row_t   stim_rows[$];
  bit          calm;
  int unsigned vertices_sent;
  int unsigned polygons_sent;
  int unsigned hits_seen;
  int unsigned misses_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Sign of n1/d1 - n2/d2 for positive denominators.
  function automatic int frac_sign(longint n1, longint d1, longint n2, longint d2);
    logic signed [127:0] lhs;
    logic signed [127:0] rhs;
    lhs = 128'(n1);
    lhs = lhs * 128'(d2);
    rhs = 128'(n2);
    rhs = rhs * 128'(d1);
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  task automatic clip_edge(input logic signed [CW-1:0] ax, ay, bx, by);
    longint nx;
    longint ny;
    longint num;
    longint den;
    nx = longint'(by) - longint'(ay);
    ny = longint'(ax) - longint'(bx);
    num = (longint'(ax) - longint'(ray_ox)) * nx + (longint'(ay) - longint'(ray_oy)) * ny;
    den = longint'(ray_dx) * nx + longint'(ray_dy) * ny;
    if (ray_dead) return;
    if (den == 0) begin
      if (num < 0) ray_dead = 1'b1;
      return;
    end
    if (den < 0) begin
      num = -num;
      den = -den;
      if (!exit_open && frac_sign(num, den, exit_num, exit_den) > 0) begin
        ray_dead = 1'b1;
        return;
      end
      if (frac_sign(num, den, entry_num, entry_den) > 0) begin
        entry_num = 36'(num);
        entry_den = 36'(den);
      end
    end else begin
      if (frac_sign(num, den, entry_num, entry_den) < 0) begin
        ray_dead = 1'b1;
        return;
      end
      if (exit_open || frac_sign(num, den, exit_num, exit_den) < 0) begin
        exit_num = 36'(num);
        exit_den = 36'(den);
        exit_open = 1'b0;
      end
    end
  endtask

  task automatic predict_vertex(input vertex_t v, output bit has_result, output bit hit);
    if (v.first) begin
      ray_ox = v.org_x;
      ray_oy = v.org_y;
      ray_dx = v.dir_x;
      ray_dy = v.dir_y;
      open_x = v.vx;
      open_y = v.vy;
      entry_num = 36'sd0;
      entry_den = 36'sd1;
      exit_num = 36'sd0;
      exit_den = 36'sd1;
      exit_open = 1'b1;
      ray_dead = 1'b0;
    end else begin
      clip_edge(prev_x, prev_y, v.vx, v.vy);
    end
    prev_x = v.vx;
    prev_y = v.vy;
    has_result = v.last;
    hit = 1'b0;
    if (v.last) begin
      clip_edge(v.vx, v.vy, open_x, open_y);
      hit = !ray_dead;
    end
  endtask

  function automatic void add_row(int x, int y, int ox, int oy, int dx, int dy,
                                  bit f, bit l, verdict_e w);
    stim_row_t row;
    row.v.vx = CW'(x);
    row.v.vy = CW'(y);
    row.v.org_x = CW'(ox);
    row.v.org_y = CW'(oy);
    row.v.dir_x = CW'(dx);
    row.v.dir_y = CW'(dy);
    row.v.first = f;
    row.v.last = l;
    row.want = w;
    stim_rows.push_back(row);
  endfunction

  function automatic longint spread(longint half);
    return longint'($urandom_range(0, 32'(2 * half))) - half;
  endfunction

  function automatic logic signed [CW-1:0] to_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return CW'(v);
  endfunction

  task automatic send_vertex(input vertex_t v, input verdict_e want);
    bit has_result;
    bit hit;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= DATA_W'({v.dir_y, v.dir_x, v.org_y, v.org_x, v.vy, v.vx});
    s_axis_tuser <= v.first;
    s_axis_tlast <= v.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    vertices_sent++;
    predict_vertex(v, has_result, hit);
    if (has_result) begin
      if (want == VERDICT_HIT) hit = 1'b1;
      else if (want == VERDICT_MISS) hit = 1'b0;
      hit_expect_q.push_back(hit);
    end
  endtask

  task automatic send_polygon();
    int n;
    int i;
    int pick;
    bit ccw;
    longint cx;
    longint cy;
    longint r;
    longint ox;
    longint oy;
    real base;
    real step;
    real ang;
    vertex_t v;
    n = $urandom_range(3, 8);
    ccw = ($urandom_range(0, 4) != 0);
    pick = $urandom_range(0, 9);
    if (pick < 7) r = longint'($urandom_range(4, 2000));
    else if (pick < 9) r = longint'($urandom_range(2001, 16000));
    else r = longint'($urandom_range(16001, 46000));
    cx = (r > 16000) ? spread(2000) : spread(32767 - r);
    cy = (r > 16000) ? spread(2000) : spread(32767 - r);
    if ($urandom_range(0, 1) == 1) begin
      ox = cx + spread(r / 2);
      oy = cy + spread(r / 2);
    end else begin
      ox = cx + spread(3 * r);
      oy = cy + spread(3 * r);
    end
    step = TWO_PI / n;
    base = $urandom_range(0, 359) * TWO_PI / 360.0;
    for (i = 0; i < n; i++) begin
      ang = step * i + step * 0.8 * $urandom_range(0, 100) / 100.0;
      if (!ccw) ang = -ang;
      ang = ang + base;
      v.vx = to_coord(cx + longint'($rtoi(r * $cos(ang))));
      v.vy = to_coord(cy + longint'($rtoi(r * $sin(ang))));
      v.first = (i == 0);
      v.last = (i == n - 1);
      if (i == 0) begin
        v.org_x = to_coord(ox);
        v.org_y = to_coord(oy);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          v.dir_x = CW'(spread(1));
          v.dir_y = CW'(spread(1));
        end else if (pick < 5) begin
          v.dir_x = CW'($urandom);
          v.dir_y = CW'($urandom);
        end else begin
          v.dir_x = CW'(spread(100));
          v.dir_y = CW'(spread(100));
        end
      end else begin
        // The ray fields only count on the opening vertex.
        v.org_x = CW'($urandom);
        v.org_y = CW'($urandom);
        v.dir_x = CW'($urandom);
        v.dir_y = CW'($urandom);
      end
      send_vertex(v, VERDICT_PREDICT);
    end
    polygons_sent++;
  endtask

  task automatic send_noise();
    vertex_t v;
    repeat ($urandom_range(1, 6)) begin
      v.vx = CW'($urandom);
      v.vy = CW'($urandom);
      v.org_x = CW'($urandom);
      v.org_y = CW'($urandom);
      v.dir_x = CW'($urandom);
      v.dir_y = CW'($urandom);
      v.first = ($urandom_range(0, 2) == 0);
      v.last = ($urandom_range(0, 2) == 0);
      send_vertex(v, VERDICT_PREDICT);
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: result mismatch, %s", $time, what);
  endtask

  always @(posedge clk_i) begin : result_check
    bit want_hit;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tdata[0]) hits_seen++;
      else misses_seen++;
      if (hit_expect_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result hit=%0b", m_axis_tdata[0]));
      end else begin
        want_hit = hit_expect_q.pop_front();
        if (m_axis_tdata[0] !== want_hit)
          note_mismatch($sformatf("hit expected %0b actual %0b", want_hit, m_axis_tdata[0]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no request moved for %0d cycles.", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  initial begin
    int k;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    calm = 1'b0;
    quiet_cycles = 0;

    // Continuation of the all-zero state after reset: every edge is parallel
    // to a zero ray and lies on the inner side, so the ray hits.
    add_row(100, 200, 0, 0, 0, 0, 1'b0, 1'b0, VERDICT_PREDICT);
    add_row(-50, 30, 7, 7, 7, 7, 1'b0, 1'b1, VERDICT_HIT);
    // Single-vertex polygon with a degenerate closing edge.
    add_row(5, 5, 0, 0, 1, 0, 1'b1, 1'b1, VERDICT_HIT);
    // Square with the origin inside.
    add_row(-100, -100, 0, 0, 1, 0, 1'b1, 1'b0, VERDICT_PREDICT);
    add_row(100, -100, 0, 0, 0, 0, 1'b0, 1'b0, VERDICT_PREDICT);
    add_row(100, 100, 0, 0, 0, 0, 1'b0, 1'b0, VERDICT_PREDICT);
    add_row(-100, 100, 0, 0, 0, 0, 1'b0, 1'b1, VERDICT_HIT);
    // Origin outside, pointing away: rejected on a leaving edge.
    add_row(-100, -100, 300, 0, 1, 0, 1'b1, 1'b0, VERDICT_PREDICT);
    add_row(100, -100, 0, 0, 0, 0, 1'b0, 1'b0, VERDICT_PREDICT);
    add_row(100, 100, 0, 0, 0, 0, 1'b0, 1'b0, VERDICT_PREDICT);
    add_row(-100, 100, 0, 0, 0, 0, 1'b0, 1'b1, VERDICT_MISS);
    // Ray parallel to the top edge and outside it.
    add_row(-100, -100, 0, 300, 1, 0, 1'b1, 1'b0, VERDICT_PREDICT);
    add_row(100, -100, 0, 0, 0, 0, 1'b0, 1'b0, VERDICT_PREDICT);
    add_row(100, 100, 0, 0, 0, 0, 1'b0, 1'b0, VERDICT_PREDICT);
    add_row(-100, 100, 0, 0, 0, 0, 1'b0, 1'b1, VERDICT_MISS);
    // Diagonal ray passing the corner: entry rises above a bounded exit.
    add_row(-100, -100, -300, 0, 1, 1, 1'b1, 1'b0, VERDICT_PREDICT);
    add_row(100, -100, 0, 0, 0, 0, 1'b0, 1'b0, VERDICT_PREDICT);
    add_row(100, 100, 0, 0, 0, 0, 1'b0, 1'b0, VERDICT_PREDICT);
    add_row(-100, 100, 0, 0, 0, 0, 1'b0, 1'b1, VERDICT_PREDICT);
    // Full-range triangles in both orientations.
    add_row(-32768, -32768, 32767, 32767, -32768, -32768, 1'b1, 1'b0, VERDICT_PREDICT);
    add_row(32767, -32768, -32768, 32767, 32767, -32768, 1'b0, 1'b0, VERDICT_PREDICT);
    add_row(0, 32767, 0, -32768, -1, 32767, 1'b0, 1'b1, VERDICT_PREDICT);
    add_row(32767, 32767, -32768, -32768, 32767, -1, 1'b1, 1'b0, VERDICT_PREDICT);
    add_row(32767, -32768, -1, -1, -1, -1, 1'b0, 1'b0, VERDICT_PREDICT);
    add_row(-32768, -32768, 0, 0, 0, 0, 1'b0, 1'b1, VERDICT_PREDICT);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < stim_rows.size(); k++) send_vertex(stim_rows[k].v, stim_rows[k].want);

    while (vertices_sent < ITEM_TARGET) begin
      calm = (vertices_sent >= CALM_FROM);
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_polygon();
    end
    s_axis_tvalid <= 1'b0;

    while (hit_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d vertices: %0d table rows and %0d random convex polygons plus",
             vertices_sent, stim_rows.size(), polygons_sent);
    $display("stray vertices, giving %0d hits and %0d misses.", hits_seen, misses_seen);
    if (mismatches == 0 && hit_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/rcpc_pkg.sv
hw/rtl/rcpc_datapath.sv
hw/rtl/rcpc_seq.sv
hw/rtl/ray_convex_polygon_clip_test.sv
bench/tb.sv
